@@ design/assert_macros.svh @@
// assertion macros used by the window unit design file
// no dependencies; expects clk and rst_n in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same check, but also evaluated while reset is held
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/narw_pkg.sv @@
// types and constants of the nonce anti-replay window unit
// no dependencies
package narw_pkg;

  localparam int unsigned NONCE_W = 56;   // 7-byte nonce
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned WCNT_W  = 7;
  localparam int unsigned WSEC_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned MS_PER_S  = 1000;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IS_INITIATOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 2'd2;

  // item actions
  localparam logic ACT_SEND  = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  typedef enum logic [2:0] {
    VERD_SENT      = 3'd0,
    VERD_NEW       = 3'd1,
    VERD_REORDERED = 3'd2,
    VERD_DUPLICATE = 3'd3,
    VERD_PARITY    = 3'd4,
    VERD_STALE     = 3'd5,
    VERD_OUTSIDE   = 3'd6,
    VERD_AUTH_FAIL = 3'd7
  } verdict_t;

  typedef struct packed {
    logic               action;
    logic [NONCE_W-1:0] nonce_in;
    logic               auth_ok;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic [NONCE_W-1:0] nonce_out;
    verdict_t           verdict;
  } out_item_t;

endpackage

@@ design/nonce_anti_replay_window_unit.sv @@
// nonce anti-replay window unit: send nonce sequencer and replay check
// depends on narw_pkg and assert_macros.svh
//
// One item per clock, sustained while out_ready drains the result register. An
// item transferred on the input lands in an input register; once the result
// register is free the whole check (parity, 56-bit age subtract, elapsed-time
// compare against window_seconds*1000, count limit, seen-map test, map shift)
// runs in one pass of logic into the result register and updates the session
// state in the same edge; the result is then offered from the result register.
// That loop through last_received and the seen map, closed in one pass of
// logic, is what allows one item per clock.
// in_ready stays high while either register is empty or being drained, so
// a waiting result does not stall the input side until a second item is
// queued. A send item (action 0) returns the current send nonce and steps it
// by 2; a check item (action 1) returns a verdict: 1 new, 2 reordered,
// 3 duplicate, 4 wrong parity, 5 stale, 6 outside window, 7 auth fail.
// Writing is_initiator restarts the session: both nonces, the last-new time
// and the seen map go back to their reset values for the chosen role.
// Configuration writes are always taken (cfg_ready is tied high) and must only
// be issued while no item is in flight.
`include "assert_macros.svh"

module nonce_anti_replay_window_unit
  import narw_pkg::*;
#(
  parameter int unsigned WINDOW_BITS = 64   // seen map depth, 8..64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int unsigned SW    = $clog2(WINDOW_BITS);
  localparam int unsigned AGE_W = NONCE_W - 1;
  localparam int unsigned LIM_W = WSEC_W + 10;

  // configuration
  logic              is_init_r;
  logic [WCNT_W-1:0] win_cnt_r;
  logic [WSEC_W-1:0] win_sec_r;

  // session state
  logic [NONCE_W-1:0]     send_ctr_r, send_ctr_nxt;
  logic [NONCE_W-1:0]     last_rx_r, last_rx_nxt;
  logic [TIME_W-1:0]      last_time_r, last_time_nxt;
  logic [WINDOW_BITS-1:0] seen_map_r, seen_map_nxt;

  // input register and result register
  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  logic      out_free;
  logic      proc_fire;
  logic      cfg_fire;
  verdict_t  verdict_nxt;
  logic [NONCE_W-1:0] nonce_out_nxt;

  // check datapath
  logic [NONCE_W-1:0] rx_nonce;
  logic               newer;
  logic [NONCE_W-1:0] fwd_diff;
  logic [NONCE_W-1:0] back_diff;
  logic [AGE_W-1:0]   shift;
  logic [AGE_W-1:0]   shift_m1;
  logic [AGE_W-1:0]   age;
  logic [AGE_W-1:0]   age_m1;
  logic [TIME_W-1:0]  elapsed;
  logic [LIM_W-1:0]   limit;
  logic [WINDOW_BITS-1:0] age_bit;
  logic [WINDOW_BITS-1:0] shifted_map;

  // handshakes
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = !in_valid_r || out_free;
  assign proc_fire = in_valid_r && out_free;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // forward and backward distance between received and last nonce
  assign rx_nonce  = in_data_r.nonce_in;
  assign newer     = rx_nonce > last_rx_r;
  assign fwd_diff  = rx_nonce - last_rx_r;
  assign back_diff = last_rx_r - rx_nonce;
  assign shift     = fwd_diff[NONCE_W-1:1];
  assign shift_m1  = shift - AGE_W'(1);
  assign age       = back_diff[NONCE_W-1:1];
  assign age_m1    = age - AGE_W'(1);
  assign elapsed   = in_data_r.now_ms - last_time_r;
  assign limit     = LIM_W'(win_sec_r) * LIM_W'(MS_PER_S);
  assign age_bit   = WINDOW_BITS'(1) << age_m1[SW-1:0];
  assign shifted_map = seen_map_r << shift[SW-1:0];

  always_comb begin
    send_ctr_nxt  = send_ctr_r;
    last_rx_nxt   = last_rx_r;
    last_time_nxt = last_time_r;
    seen_map_nxt  = seen_map_r;
    verdict_nxt   = VERD_SENT;
    nonce_out_nxt = '0;
    if (in_data_r.action == ACT_SEND) begin
      nonce_out_nxt = send_ctr_r;
      if (proc_fire) begin
        send_ctr_nxt = send_ctr_r + NONCE_W'(2);
      end
    end else if (rx_nonce[0] != last_rx_r[0]) begin
      verdict_nxt = VERD_PARITY;
    end else if (newer) begin
      // newer nonce: slide the map and mark the previous last nonce
      if (!in_data_r.auth_ok) begin
        verdict_nxt = VERD_AUTH_FAIL;
      end else begin
        verdict_nxt = VERD_NEW;
        if (proc_fire) begin
          if (shift >= AGE_W'(WINDOW_BITS)) begin
            seen_map_nxt = '0;
          end else begin
            seen_map_nxt = shifted_map;
          end
          if (shift <= AGE_W'(WINDOW_BITS)) begin
            seen_map_nxt[shift_m1[SW-1:0]] = 1'b1;
          end
          last_rx_nxt   = rx_nonce;
          last_time_nxt = in_data_r.now_ms;
        end
      end
    end else if (elapsed > TIME_W'(limit)) begin
      verdict_nxt = VERD_STALE;
    end else if (age > AGE_W'(win_cnt_r) || age > AGE_W'(WINDOW_BITS)) begin
      verdict_nxt = VERD_OUTSIDE;
    end else if (!in_data_r.auth_ok) begin
      verdict_nxt = VERD_AUTH_FAIL;
    end else if (age == '0 || (seen_map_r & age_bit) != '0) begin
      verdict_nxt = VERD_DUPLICATE;
    end else begin
      // older nonce inside the window, first time seen
      verdict_nxt = VERD_REORDERED;
      if (proc_fire) begin
        seen_map_nxt = seen_map_r | age_bit;
      end
    end
  end

  // configuration and session state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_init_r   <= 1'b0;
      win_cnt_r   <= WCNT_W'(64);
      win_sec_r   <= WSEC_W'(10);
      send_ctr_r  <= NONCE_W'(2);
      last_rx_r   <= NONCE_W'(1);
      last_time_r <= '0;
      seen_map_r  <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_IS_INITIATOR: begin
          // new session for the chosen role
          is_init_r   <= cfg_data[0];
          send_ctr_r  <= cfg_data[0] ? NONCE_W'(3) : NONCE_W'(2);
          last_rx_r   <= cfg_data[0] ? NONCE_W'(0) : NONCE_W'(1);
          last_time_r <= '0;
          seen_map_r  <= '0;
        end
        CFG_WINDOW_COUNT:   win_cnt_r <= cfg_data[WCNT_W-1:0];
        CFG_WINDOW_SECONDS: win_sec_r <= cfg_data[WSEC_W-1:0];
        default: ;
      endcase
    end else begin
      send_ctr_r  <= send_ctr_nxt;
      last_rx_r   <= last_rx_nxt;
      last_time_r <= last_time_nxt;
      seen_map_r  <= seen_map_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_data_r.nonce_out <= nonce_out_nxt;
      out_data_r.verdict   <= verdict_nxt;
    end
  end

  // parity of both nonces always follows the session role
  `ASSERT_CLK(a_nonce_parity, (send_ctr_r[0] == is_init_r) && (last_rx_r[0] != is_init_r), "nonce parity does not match session role")
  // only new or reordered packets may touch the receive state
  `ASSERT_CLK(a_rx_state_hold, (proc_fire && !cfg_fire && verdict_nxt != VERD_NEW && verdict_nxt != VERD_REORDERED) |=> ($stable(last_rx_r) && $stable(seen_map_r)), "receive state changed on a rejected item")
  // a new result only appears after an item sat in the input register
  `ASSERT_CLK(a_result_source, $rose(out_valid_r) |-> $past(in_valid_r), "result without a queued item")
  // the last nonce only moves forward outside a session restart
  `ASSERT_CLK(a_last_rx_forward, (!cfg_fire) |=> (last_rx_r >= $past(last_rx_r)), "last received nonce moved backward")

endmodule
